// File: design/sld_pkg.sv
`timescale 1ns / 1ps

package sld_pkg;

    // Byte and field widths fixed by the frame format.
    localparam int BYTE_W         = 8;
    localparam int LEN_W          = 16;
    localparam int CFG_DATA_W     = 32;
    localparam int CFG_ADDR_W     = 3;

    // Default number of sync bytes in the rolling window.
    localparam int SYNC_BYTES_DEF = 4;

    // Reset value of the receive buffer capacity.
    localparam logic [LEN_W-1:0] MAX_MESSAGE_RESET = 16'd256;

    // Smallest legal length: id byte plus checksum byte.
    localparam logic [LEN_W-1:0] MIN_FRAME_LENGTH = 16'd2;

    // Register indexes, taken from paddr[2].
    localparam logic CFG_SYNC_PATTERN = 1'b0;
    localparam logic CFG_MAX_MESSAGE  = 1'b1;

    // Framing phase.
    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_LEN1 = 2'd1,
        PH_LEN2 = 2'd2,
        PH_DATA = 2'd3
    } t_phase;

    // Event code of one result.
    typedef enum logic [2:0] {
        EV_IDLE      = 3'd0,
        EV_SYNC      = 3'd1,
        EV_LEN       = 3'd2,
        EV_CONTENT   = 3'd3,
        EV_GOOD      = 3'd4,
        EV_BADSUM    = 3'd5,
        EV_OVERFLOW  = 3'd6,
        EV_MALFORMED = 3'd7
    } t_event;

    // Configuration register contents.
    typedef struct packed {
        logic [CFG_DATA_W-1:0] sync_pattern;
        logic [LEN_W-1:0]      max_message_bytes;
    } t_cfg;

    // One result item.
    typedef struct packed {
        t_event             event_res;
        logic [BYTE_W-1:0]  data_byte;
        logic [LEN_W-1:0]   position;
        logic [BYTE_W-1:0]  message_id;
        logic [LEN_W-1:0]   body_len;
        logic               resync_abort;
    } t_result;

endpackage

// File: design/sld_cfg.sv
`timescale 1ns / 1ps

module sld_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sld_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [sld_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [sld_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready,
    output sld_pkg::t_cfg                       o_cfg
);

    logic [sld_pkg::CFG_DATA_W-1:0] r_sync_pattern;
    logic [sld_pkg::LEN_W-1:0]      r_max_message_bytes;
    logic                           wr_en;
    logic                           reg_idx;

    // The port never inserts wait states.
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2];

    // Register writes at the access phase of a write transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_pattern      <= '0;
            r_max_message_bytes <= sld_pkg::MAX_MESSAGE_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                sld_pkg::CFG_SYNC_PATTERN: r_sync_pattern <= pwdata;
                sld_pkg::CFG_MAX_MESSAGE:  r_max_message_bytes <= pwdata[sld_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Read data follows the address.
    always_comb begin
        case (reg_idx)
            sld_pkg::CFG_SYNC_PATTERN: prdata = r_sync_pattern;
            sld_pkg::CFG_MAX_MESSAGE:
                prdata = {{(sld_pkg::CFG_DATA_W-sld_pkg::LEN_W){1'b0}}, r_max_message_bytes};
            default: prdata = '0;
        endcase
    end

    assign o_cfg.sync_pattern      = r_sync_pattern;
    assign o_cfg.max_message_bytes = r_max_message_bytes;

endmodule

// File: design/sld_core.sv
`timescale 1ns / 1ps

module sld_core #(
    parameter int SYNC_BYTES = sld_pkg::SYNC_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  logic [sld_pkg::BYTE_W-1:0]  i_rx_byte,
    input  sld_pkg::t_cfg               i_cfg,
    output sld_pkg::t_result            o_res
);

    localparam int WIN_W = sld_pkg::BYTE_W * SYNC_BYTES;
    localparam int PAT_W = (WIN_W > sld_pkg::CFG_DATA_W) ? WIN_W : sld_pkg::CFG_DATA_W;

    logic [WIN_W-1:0]            r_window;
    logic [WIN_W-1:0]            n_window;
    sld_pkg::t_phase             r_phase;
    sld_pkg::t_phase             n_phase;
    logic [sld_pkg::LEN_W-1:0]   r_frame_length;
    logic [sld_pkg::LEN_W-1:0]   n_frame_length;
    logic [sld_pkg::LEN_W-1:0]   r_byte_count;
    logic [sld_pkg::LEN_W-1:0]   n_byte_count;
    logic [sld_pkg::BYTE_W-1:0]  r_running_xor;
    logic [sld_pkg::BYTE_W-1:0]  n_running_xor;
    logic [sld_pkg::BYTE_W-1:0]  r_held_id;
    logic [sld_pkg::BYTE_W-1:0]  n_held_id;

    logic [WIN_W+sld_pkg::BYTE_W-1:0] win_shift;
    logic [PAT_W-1:0]            pat_ext;
    logic                        sync_match;
    logic [sld_pkg::LEN_W-1:0]   full_length;
    logic                        len_short;
    logic                        overflow;
    logic [sld_pkg::LEN_W-1:0]   count_inc;
    logic                        last_byte;

    // Shared decode of the incoming byte against the current state.
    assign win_shift   = {r_window, i_rx_byte};
    assign n_window    = win_shift[WIN_W-1:0];
    assign pat_ext     = PAT_W'(i_cfg.sync_pattern);
    assign sync_match  = (n_window == pat_ext[WIN_W-1:0]);
    assign full_length = {r_frame_length[sld_pkg::LEN_W-1:sld_pkg::BYTE_W], i_rx_byte};
    assign len_short   = (full_length < sld_pkg::MIN_FRAME_LENGTH);
    assign overflow    = (r_byte_count >= i_cfg.max_message_bytes);
    assign count_inc   = r_byte_count + 16'd1;
    assign last_byte   = (count_inc >= r_frame_length);

    // Next framing phase.
    always_comb begin
        n_phase = r_phase;
        if (sync_match) begin
            n_phase = sld_pkg::PH_LEN1;
        end else begin
            case (r_phase)
                sld_pkg::PH_WAIT: n_phase = sld_pkg::PH_WAIT;
                sld_pkg::PH_LEN1: n_phase = sld_pkg::PH_LEN2;
                sld_pkg::PH_LEN2: n_phase = len_short ? sld_pkg::PH_WAIT : sld_pkg::PH_DATA;
                sld_pkg::PH_DATA: n_phase = (overflow || last_byte) ? sld_pkg::PH_WAIT
                                                                     : sld_pkg::PH_DATA;
                default: n_phase = sld_pkg::PH_WAIT;
            endcase
        end
    end

    // Result fields and datapath state for this byte.
    always_comb begin
        n_frame_length = r_frame_length;
        n_byte_count   = r_byte_count;
        n_running_xor  = r_running_xor;
        n_held_id      = r_held_id;
        o_res          = '0;
        o_res.event_res = sld_pkg::EV_IDLE;
        if (sync_match) begin
            o_res.event_res    = sld_pkg::EV_SYNC;
            o_res.resync_abort = (r_phase != sld_pkg::PH_WAIT);
            n_frame_length     = '0;
        end else begin
            case (r_phase)
                sld_pkg::PH_LEN1: begin
                    o_res.event_res = sld_pkg::EV_LEN;
                    o_res.data_byte = i_rx_byte;
                    n_frame_length  = {i_rx_byte, {sld_pkg::BYTE_W{1'b0}}};
                end
                sld_pkg::PH_LEN2: begin
                    o_res.data_byte = i_rx_byte;
                    n_byte_count    = '0;
                    n_running_xor   = '0;
                    n_held_id       = '0;
                    if (len_short) begin
                        o_res.event_res = sld_pkg::EV_MALFORMED;
                        n_frame_length  = '0;
                    end else begin
                        o_res.event_res = sld_pkg::EV_LEN;
                        n_frame_length  = full_length;
                    end
                end
                sld_pkg::PH_DATA: begin
                    if (overflow) begin
                        // Byte is dropped; report where the buffer ran out.
                        o_res.event_res  = sld_pkg::EV_OVERFLOW;
                        o_res.position   = r_byte_count;
                        o_res.message_id = (r_byte_count != '0) ? r_held_id : '0;
                        n_byte_count     = '0;
                    end else begin
                        o_res.data_byte = i_rx_byte;
                        o_res.position  = r_byte_count;
                        if (r_byte_count == '0) begin
                            n_held_id = i_rx_byte;
                        end
                        n_byte_count = count_inc;
                        if (last_byte) begin
                            // Checksum byte closes the message.
                            o_res.event_res    = (r_running_xor == i_rx_byte) ? sld_pkg::EV_GOOD
                                                                              : sld_pkg::EV_BADSUM;
                            o_res.message_id   = (r_byte_count == '0) ? i_rx_byte : r_held_id;
                            o_res.body_len     = r_frame_length - sld_pkg::MIN_FRAME_LENGTH;
                            n_frame_length     = '0;
                        end else begin
                            o_res.event_res = sld_pkg::EV_CONTENT;
                            n_running_xor   = r_running_xor ^ i_rx_byte;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // State advances once per transfer into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window       <= '0;
            r_phase        <= sld_pkg::PH_WAIT;
            r_frame_length <= '0;
            r_byte_count   <= '0;
            r_running_xor  <= '0;
            r_held_id      <= '0;
        end else if (i_fire) begin
            r_window       <= n_window;
            r_phase        <= n_phase;
            r_frame_length <= n_frame_length;
            r_byte_count   <= n_byte_count;
            r_running_xor  <= n_running_xor;
            r_held_id      <= n_held_id;
        end
    end

    // A sync match always enters the first length byte phase.
    a_sync_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_res.event_res == sld_pkg::EV_SYNC) |=> (r_phase == sld_pkg::PH_LEN1))
        else $error("sync match did not restart framing");

    // Overflow abandons the message and clears the count.
    a_overflow_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_res.event_res == sld_pkg::EV_OVERFLOW)
        |=> (r_phase == sld_pkg::PH_WAIT && r_byte_count == '0))
        else $error("overflow did not return to waiting");

    // Content is only collected for a length that holds an id and a checksum.
    a_data_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == sld_pkg::PH_DATA) |-> (r_frame_length >= sld_pkg::MIN_FRAME_LENGTH))
        else $error("content phase with a short length");

    // The abort flag only comes with a sync event.
    a_abort_on_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.resync_abort |-> (o_res.event_res == sld_pkg::EV_SYNC))
        else $error("resync abort without a sync event");

endmodule

// File: design/sync_length_xor_deframer.sv
`timescale 1ns / 1ps

// Sync-word, length-prefixed frame receiver with XOR checksum.
// Input channel: one received byte per transfer on i_rx_byte, taken when
// i_in_valid is high and o_in_stall is low. Output channel: one result per
// input byte (event code, echoed byte, content position, message id,
// payload size, resync flag), taken when o_out_valid is high and
// i_out_stall is low.
// Path: a byte accepted lands in the input register, its result is
// computed from that register and the framing state and is captured in
// the output register, from which it is taken. Throughput is one byte per
// cycle while the receiver does not stall, set by the single registered
// pass through the framing logic.
// When the receiver stalls, the result holds in the output register while
// one more byte may wait in the input register; o_in_stall rises only when
// both are full.
// Reset (synchronous, active low) empties both registers, returns framing
// to waiting for sync with a cleared window, and loads the configuration
// defaults: sync pattern zero, capacity 256 bytes. The APB port writes
// sync_pattern at 0x0 and max_message_bytes at 0x4; write only while idle.
module sync_length_xor_deframer #(
    parameter int SYNC_BYTES = sld_pkg::SYNC_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sld_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [sld_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [sld_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [sld_pkg::BYTE_W-1:0]          i_rx_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [2:0]                          o_event_res,
    output logic [sld_pkg::BYTE_W-1:0]          o_data_byte,
    output logic [sld_pkg::LEN_W-1:0]           o_position,
    output logic [sld_pkg::BYTE_W-1:0]          o_message_id,
    output logic [sld_pkg::LEN_W-1:0]           o_body_len,
    output logic                                o_resync_abort
);

    sld_pkg::t_cfg               cfg;
    sld_pkg::t_result            step_res;
    logic                        r_in_valid;
    logic [sld_pkg::BYTE_W-1:0]  r_in_byte;
    logic                        r_out_valid;
    sld_pkg::t_result            r_out;
    logic                        out_advance;
    logic                        fire;

    sld_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Pipeline flow control: output register frees when empty or taken.
    assign out_advance = !r_out_valid || !i_out_stall;
    assign fire        = r_in_valid && out_advance;
    assign o_in_stall  = r_in_valid && !out_advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    sld_core #(
        .SYNC_BYTES (SYNC_BYTES)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_rx_byte (r_in_byte),
        .i_cfg     (cfg),
        .o_res     (step_res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_res    = r_out.event_res;
    assign o_data_byte    = r_out.data_byte;
    assign o_position     = r_out.position;
    assign o_message_id   = r_out.message_id;
    assign o_body_len     = r_out.body_len;
    assign o_resync_abort = r_out.resync_abort;

endmodule

// File: tb/tb_sync_length_xor_deframer.sv
`timescale 1ns / 1ps

module tb_sync_length_xor_deframer;

    localparam int SYNC_BYTES        = sld_pkg::SYNC_BYTES_DEF;
    localparam logic [63:0] WIN_MASK = (SYNC_BYTES >= 8) ? {64{1'b1}} :
                                       ((64'd1 << (8 * SYNC_BYTES)) - 64'd1);
    localparam int ITEMS_PER_SETTING = 100;
    localparam int LONG_HOLD_CYCLES  = 80;
    localparam int TAIL_CYCLES       = 4;
    localparam int WATCHDOG_LIMIT    = 1000;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [sld_pkg::CFG_ADDR_W-1:0]  paddr;
    logic [sld_pkg::CFG_DATA_W-1:0]  pwdata;
    logic [sld_pkg::CFG_DATA_W-1:0]  prdata;
    logic                            pready;
    logic                            i_in_valid;
    logic                            o_in_stall;
    logic [sld_pkg::BYTE_W-1:0]      i_rx_byte;
    logic                            o_out_valid;
    logic                            i_out_stall;
    logic [2:0]                      o_event_res;
    logic [sld_pkg::BYTE_W-1:0]      o_data_byte;
    logic [sld_pkg::LEN_W-1:0]       o_position;
    logic [sld_pkg::BYTE_W-1:0]      o_message_id;
    logic [sld_pkg::LEN_W-1:0]       o_body_len;
    logic                            o_resync_abort;

    // Configuration as last written, and the framing state that follows it.
    logic [31:0]                     cfg_pattern;
    logic [sld_pkg::LEN_W-1:0]       cfg_capacity;
    logic [63:0]                     sync_win;
    sld_pkg::t_phase                 frame_phase;
    logic [sld_pkg::LEN_W-1:0]       frame_len;
    logic [sld_pkg::LEN_W-1:0]       content_cnt;
    logic [sld_pkg::BYTE_W-1:0]      xor_acc;
    logic [sld_pkg::BYTE_W-1:0]      id_hold;

    sld_pkg::t_result                pending_results[$];
    int                              fail_count = 0;
    int                              items_sent;
    int                              quiet_cycles = 0;
    bit                              tx_idle_en;
    bit                              rx_idle_en;
    bit                              long_hold_req;

    sync_length_xor_deframer i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_event_res    (o_event_res),
        .o_data_byte    (o_data_byte),
        .o_position     (o_position),
        .o_message_id   (o_message_id),
        .o_body_len     (o_body_len),
        .o_resync_abort (o_resync_abort)
    );

    // Free-running 2 ns clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Idle lengths: mostly none, some short, a few long.
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Byte k of the sync word, counted from the newest byte.
    function automatic logic [7:0] sync_byte(input int k);
        return 8'(cfg_pattern >> (8 * k));
    endfunction

    // Advances the framing state by one received byte and returns its result.
    function automatic sld_pkg::t_result deframe_byte(input logic [7:0] b);
        sld_pkg::t_result r;
        r = '0;
        r.event_res = sld_pkg::EV_IDLE;
        sync_win = ((sync_win << 8) | {56'h0, b}) & WIN_MASK;
        if (sync_win == ({32'h0, cfg_pattern} & WIN_MASK)) begin
            // A sync match wins over everything and drops any message in flight.
            r.event_res    = sld_pkg::EV_SYNC;
            r.resync_abort = (frame_phase != sld_pkg::PH_WAIT);
            frame_phase    = sld_pkg::PH_LEN1;
            frame_len      = '0;
        end else begin
            case (frame_phase)
                sld_pkg::PH_LEN1: begin
                    r.event_res = sld_pkg::EV_LEN;
                    r.data_byte = b;
                    frame_len   = {b, 8'h00};
                    frame_phase = sld_pkg::PH_LEN2;
                end
                sld_pkg::PH_LEN2: begin
                    r.data_byte = b;
                    frame_len   = frame_len | {8'h00, b};
                    content_cnt = '0;
                    xor_acc     = '0;
                    id_hold     = '0;
                    if (frame_len < sld_pkg::MIN_FRAME_LENGTH) begin
                        r.event_res = sld_pkg::EV_MALFORMED;
                        frame_phase = sld_pkg::PH_WAIT;
                        frame_len   = '0;
                    end else begin
                        r.event_res = sld_pkg::EV_LEN;
                        frame_phase = sld_pkg::PH_DATA;
                    end
                end
                sld_pkg::PH_DATA: begin
                    if (content_cnt >= cfg_capacity) begin
                        // Buffer full: the byte is dropped and framing restarts.
                        r.event_res  = sld_pkg::EV_OVERFLOW;
                        r.position   = content_cnt;
                        r.message_id = (content_cnt != 0) ? id_hold : 8'h00;
                        frame_phase  = sld_pkg::PH_WAIT;
                        content_cnt  = '0;
                    end else begin
                        r.data_byte = b;
                        r.position  = content_cnt;
                        if (content_cnt == 0) id_hold = b;
                        content_cnt = content_cnt + 16'd1;
                        if (content_cnt >= frame_len) begin
                            r.event_res  = (xor_acc == b) ? sld_pkg::EV_GOOD
                                                          : sld_pkg::EV_BADSUM;
                            r.message_id = id_hold;
                            r.body_len   = frame_len - 16'd2;
                            frame_phase  = sld_pkg::PH_WAIT;
                            frame_len    = '0;
                        end else begin
                            r.event_res = sld_pkg::EV_CONTENT;
                            xor_acc     = xor_acc ^ b;
                        end
                    end
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    // Offers one byte, waits for its transfer and records the predicted result.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_idle_en ? idle_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(deframe_byte(b));
        items_sent++;
    endtask

    task automatic send_sync();
        int k;
        for (k = SYNC_BYTES - 1; k >= 0; k--) send_byte(sync_byte(k));
    endtask

    // Sync, length, then the first count content bytes; the last byte of a
    // complete frame is the checksum, optionally corrupted.
    task automatic send_frame(input logic [15:0] len, input int count, input bit bad_sum);
        logic [7:0] sum;
        logic [7:0] b;
        int         k;
        send_sync();
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        sum = 8'h00;
        for (k = 0; k < count; k++) begin
            if (k == int'(len) - 1) begin
                b = bad_sum ? (sum ^ 8'($urandom_range(1, 255))) : sum;
            end else begin
                b   = 8'($urandom);
                sum = sum ^ b;
            end
            send_byte(b);
        end
    endtask

    // Stops offering and waits until every predicted result has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, access cycle until pready, then back to idle.
    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == sld_pkg::CFG_SYNC_PATTERN) cfg_pattern = value;
        else cfg_capacity = value[15:0];
        @(posedge i_clk);
    endtask

    // One random frame: mostly complete, some malformed, cut short, or noise.
    task automatic send_random_frame();
        int kind;
        int len;
        kind = $urandom_range(0, 99);
        if (kind < 65) begin
            len = $urandom_range(2, 14);
            send_frame(16'(len), len, $urandom_range(0, 4) == 0);
        end else if (kind < 75) begin
            send_frame(16'($urandom_range(0, 1)), 0, 1'b0);
        end else if (kind < 90) begin
            send_frame(16'($urandom_range(15, 65535)), $urandom_range(0, 6), 1'b0);
        end else begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        end
    endtask

    // Noise byte, cut-off longest frame, resync into a bad-checksum frame,
    // then a good frame with no payload.
    task automatic test_directed();
        write_reg(sld_pkg::CFG_SYNC_PATTERN, 32'hA5C3_5A3C);
        send_byte(8'h11);
        send_sync();
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_sync();
        send_byte(8'h00);
        send_byte(8'h03);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_sync();
        send_byte(8'h00);
        send_byte(8'h02);
        send_byte(8'hFF);
        send_byte(8'hFF);
    endtask

    // Random traffic under a series of register settings, extremes included.
    task automatic test_random_frames();
        logic [31:0] pat;
        logic [15:0] cap;
        int          s;
        int          stop_at;
        for (s = 0; s < 8; s++) begin
            pat = $urandom;
            case (s)
                0: begin pat = 32'h0000_0000; cap = 16'hFFFF; end
                1: begin pat = 32'hFFFF_FFFF; cap = 16'd1; end
                2: cap = 16'd0;
                3: cap = 16'($urandom_range(2, 12));
                4: cap = sld_pkg::MAX_MESSAGE_RESET;
                5: cap = 16'($urandom_range(1, 40));
                6: cap = 16'hFFFF;
                default: cap = 16'd8;
            endcase
            drain();
            write_reg(sld_pkg::CFG_SYNC_PATTERN, pat);
            write_reg(sld_pkg::CFG_MAX_MESSAGE, {16'h0000, cap});
            tx_idle_en = (s % 3 != 2);
            rx_idle_en = tx_idle_en;
            stop_at = items_sent + ITEMS_PER_SETTING;
            while (items_sent < stop_at) send_random_frame();
        end
    endtask

    // The receiver holds off for a long stretch while bytes keep coming.
    task automatic test_backpressure();
        drain();
        write_reg(sld_pkg::CFG_MAX_MESSAGE, 32'd256);
        tx_idle_en    = 1'b0;
        rx_idle_en    = 1'b0;
        long_hold_req = 1'b1;
        repeat (3) send_frame(16'd14, 14, 1'b0);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // Receiver stall pattern, including the long hold-off on request.
    initial begin : out_stall_gen
        int hold;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_stall <= 1'b1;
                hold = LONG_HOLD_CYCLES;
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                hold = idle_gap() + 1;
            end else begin
                i_out_stall <= 1'b0;
                hold = rx_idle_en ? $urandom_range(1, 8) : 1;
            end
            repeat (hold) @(posedge i_clk);
        end
    end

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v) begin
            fail_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want_v, got_v);
        end
    endtask

    // Compare each result transfer with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        sld_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                $display("%0t: result with none pending, expected nothing, actual event %0d",
                         $time, o_event_res);
            end else begin
                want = pending_results.pop_front();
                check_field("event_res", 16'(want.event_res), 16'(o_event_res));
                check_field("data_byte", 16'(want.data_byte), 16'(o_data_byte));
                check_field("position", want.position, o_position);
                check_field("message_id", 16'(want.message_id), 16'(o_message_id));
                check_field("body_len", want.body_len, o_body_len);
                check_field("resync_abort", 16'(want.resync_abort), 16'(o_resync_abort));
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Reset, run the tests in turn, then report.
    initial begin
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        i_in_valid    <= 1'b0;
        i_rx_byte     <= '0;
        items_sent    = 0;
        tx_idle_en    = 1'b1;
        rx_idle_en    = 1'b1;
        long_hold_req = 1'b0;
        cfg_pattern   = '0;
        cfg_capacity  = sld_pkg::MAX_MESSAGE_RESET;
        sync_win      = '0;
        frame_phase   = sld_pkg::PH_WAIT;
        frame_len     = '0;
        content_cnt   = '0;
        xor_acc       = '0;
        id_hold       = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_frames();
        test_backpressure();
        drain();
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
